### src/io_interrupt_bank_controller_macros.svh
`ifndef IO_INTERRUPT_BANK_CONTROLLER_MACROS_SVH
`define IO_INTERRUPT_BANK_CONTROLLER_MACROS_SVH

// Each check samples on clk and is off while arst_n is low.
`define IOBC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define IOBC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define IOBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/iobc_pkg.sv
package iobc_pkg;

	localparam int RAM_PAGE_CNT_DEF = 4;
	localparam int ROM_PAGE_CNT_DEF = 8;

	localparam int REQ_W    = 3;
	localparam int PORT_W   = 16;
	localparam int ADDR_W   = 20;
	localparam int BYTE_W   = 8;
	localparam int ROW_W    = 4;
	localparam int BIT_W    = 3;
	localparam int KIND_W   = 2;
	localparam int PHYS_W   = 21;
	localparam int OFFS_W   = 17;
	localparam int PAGE_W   = 4;
	localparam int SEL_W    = 5;
	localparam int TICK_W   = 16;
	localparam int SHOT_W   = 24;
	localparam int CFG_IDX_W = 1;
	localparam int KEY_ROWS = 10;
	localparam int BANKS    = 8;

	localparam logic [REQ_W-1:0] REQ_IO_READ   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_IO_WRITE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MAP_QUERY = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TICK      = 3'd3;
	localparam logic [REQ_W-1:0] REQ_KEY_DOWN  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_KEY_UP    = 3'd5;
	localparam logic [REQ_W-1:0] REQ_PWR_PRESS = 3'd6;
	localparam logic [REQ_W-1:0] REQ_PWR_REL   = 3'd7;

	localparam logic [KIND_W-1:0] KIND_ROM  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RAM  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_TICK_UNIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT3_RAM  = 1'd1;

	localparam logic [PORT_W-1:0] P_LCD      = 16'h0000;
	localparam logic [PORT_W-1:0] P_BANK     = 16'h0010;
	localparam logic [PORT_W-1:0] P_BUZZER   = 16'h0052;
	localparam logic [PORT_W-1:0] P_ONESHOT  = 16'h0053;
	localparam logic [PORT_W-1:0] P_IRQ_EN   = 16'h0060;
	localparam logic [PORT_W-1:0] P_SCAN_CTL = 16'h0061;
	localparam logic [PORT_W-1:0] P_HALT     = 16'h0070;
	localparam logic [PORT_W-1:0] P_IRQ_ACK  = 16'h0090;
	localparam logic [PORT_W-1:0] P_ID       = 16'h00A0;
	localparam logic [PORT_W-1:0] P_KEYS     = 16'h00B0;
	localparam logic [PORT_W-1:0] P_STAT0    = 16'h00C0;
	localparam logic [PORT_W-1:0] P_STAT1    = 16'h00C1;
	localparam logic [PORT_W-1:0] P_ZERO_BLK = 16'h00D0;

	localparam logic [BYTE_W-1:0] ID_VALUE    = 8'h80;
	localparam logic [BYTE_W-1:0] STAT1_VALUE = 8'h05;
	localparam logic [BYTE_W-1:0] BUZZ_ON_VAL = 8'h7F;
	localparam logic [BYTE_W-1:0] OPEN_BUS    = 8'hFF;
	localparam logic [BYTE_W-1:0] SCAN_CTL_RST = 8'hFF;
	localparam logic [BYTE_W-1:0] IRQ_POWER   = 8'h01;
	localparam logic [BYTE_W-1:0] IRQ_ROW     = 8'h10;
	localparam logic [BYTE_W-1:0] IRQ_SCAN    = 8'h20;
	localparam logic [BYTE_W-1:0] IRQ_SCAN_BOTH = 8'h30;
	localparam logic [BYTE_W-1:0] IRQ_ONESHOT = 8'h40;
	localparam logic [ROW_W-1:0]  LAST_ROW    = 4'd9;
	localparam logic [TICK_W-1:0] TICK_UNIT_RST = 16'd1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PHYS_W-1:0] phys;
	} map_res_t;

	function automatic logic [BYTE_W-1:0] bit_rev(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] irq_vec(input logic [BYTE_W-1:0] pend);
		logic [2:0] idx;
		idx = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (pend[i]) begin
				idx = 3'(i);
			end
		end
		return (pend == '0) ? '0 : {5'h1F, ~idx};
	endfunction

endpackage

### src/iobc_map.sv
module iobc_map #(
	parameter int RAM_PAGE_CNT = iobc_pkg::RAM_PAGE_CNT_DEF,
	parameter int ROM_PAGE_CNT = iobc_pkg::ROM_PAGE_CNT_DEF
) (
	input  logic [iobc_pkg::SEL_W-1:0]  sel,
	input  logic [2:0]                  bank,
	input  logic [iobc_pkg::OFFS_W-1:0] offset,
	input  logic                        bit3_ram,
	output iobc_pkg::map_res_t          res
);

	localparam int TBL = 1 << iobc_pkg::PAGE_W;

	logic [iobc_pkg::PAGE_W-1:0] rom_page_tbl [TBL];
	logic [iobc_pkg::PAGE_W-1:0] ram_page_tbl [TBL];
	logic [iobc_pkg::PAGE_W-1:0] inv;
	logic [iobc_pkg::PAGE_W-1:0] page;

	for (genvar g = 0; g < TBL; g++) begin : g_tbl
		assign rom_page_tbl[g] = iobc_pkg::PAGE_W'(g % ROM_PAGE_CNT);
		assign ram_page_tbl[g] = iobc_pkg::PAGE_W'(g % RAM_PAGE_CNT);
	end

	assign inv = sel[3:0] ^ 4'hF;

	always_comb begin
		page = '0;
		res.kind = iobc_pkg::KIND_NONE;
		unique case (sel[4:3])
			2'b00: begin
				page = rom_page_tbl[inv];
				res.kind = iobc_pkg::KIND_ROM;
			end
			2'b01: begin
				page = bit3_ram ? ram_page_tbl[{1'b0, bank}] : ram_page_tbl[4'd1];
				res.kind = iobc_pkg::KIND_RAM;
			end
			2'b10: begin
				page = ram_page_tbl[inv];
				res.kind = iobc_pkg::KIND_RAM;
			end
			2'b11: begin
				res.kind = iobc_pkg::KIND_NONE;
			end
		endcase
		res.phys = (res.kind == iobc_pkg::KIND_NONE) ? '0 : {page, offset};
	end

endmodule

### src/io_interrupt_bank_controller.sv
// channel  dir  handshake            fields
// request  in   req_valid/req_stall  req_type port mem_addr data key_row key_bit
// result   out  rsp_valid/rsp_stall  read_data irq_request irq_vector map_kind
//                                    map_phys_addr cpu_halted lcd_enabled lcd_base
//                                    buzzer_enabled
// config   in   cfg_we               cfg_index cfg_data
//
// One item per cycle while the result is not stalled; each taken item passes the input
// register, then the state update and result register, before its result is offered.
// The rate is set by the state update, which closes on the input register.
// arst_n resets the control state; tick_unit_q and bit3_ram_q reset to 1.
// A stalled result holds the item in the input register; requests stall only when
// the input register cannot move on.
`include "io_interrupt_bank_controller_macros.svh"

module io_interrupt_bank_controller #(
	parameter int RAM_PAGE_CNT = iobc_pkg::RAM_PAGE_CNT_DEF,
	parameter int ROM_PAGE_CNT = iobc_pkg::ROM_PAGE_CNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_we,
	input  logic [iobc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [iobc_pkg::TICK_W-1:0]    cfg_data,

	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [iobc_pkg::REQ_W-1:0]     req_type,
	input  logic [iobc_pkg::PORT_W-1:0]    port,
	input  logic [iobc_pkg::ADDR_W-1:0]    mem_addr,
	input  logic [iobc_pkg::BYTE_W-1:0]    data,
	input  logic [iobc_pkg::ROW_W-1:0]     key_row,
	input  logic [iobc_pkg::BIT_W-1:0]     key_bit,

	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [iobc_pkg::BYTE_W-1:0]    read_data,
	output logic                           irq_request,
	output logic [iobc_pkg::BYTE_W-1:0]    irq_vector,
	output logic [iobc_pkg::KIND_W-1:0]    map_kind,
	output logic [iobc_pkg::PHYS_W-1:0]    map_phys_addr,
	output logic                           cpu_halted,
	output logic                           lcd_enabled,
	output logic [iobc_pkg::BYTE_W-1:0]    lcd_base,
	output logic                           buzzer_enabled
);

	logic                         valid_s1;
	logic [iobc_pkg::REQ_W-1:0]   req_type_s1;
	logic [iobc_pkg::PORT_W-1:0]  port_s1;
	logic [iobc_pkg::ADDR_W-1:0]  mem_addr_s1;
	logic [iobc_pkg::BYTE_W-1:0]  data_s1;
	logic [iobc_pkg::ROW_W-1:0]   key_row_s1;
	logic [iobc_pkg::BIT_W-1:0]   key_bit_s1;

	logic                         in_fire;
	logic                         adv;

	logic [iobc_pkg::TICK_W-1:0]  tick_unit_q;
	logic                         bit3_ram_q;

	logic [iobc_pkg::BYTE_W-1:0]  irq_en_q,   irq_en_d;
	logic [iobc_pkg::BYTE_W-1:0]  irq_pend_q, irq_pend_d;
	logic [iobc_pkg::SEL_W-1:0]   bank_sel_q [iobc_pkg::BANKS];
	logic [iobc_pkg::SEL_W-1:0]   bank_sel_d [iobc_pkg::BANKS];
	logic [iobc_pkg::BYTE_W-1:0]  key_mat_q  [iobc_pkg::KEY_ROWS];
	logic [iobc_pkg::BYTE_W-1:0]  key_mat_d  [iobc_pkg::KEY_ROWS];
	logic [iobc_pkg::ROW_W-1:0]   scan_row_q,  scan_row_d;
	logic [iobc_pkg::BYTE_W-1:0]  scan_ctl_q,  scan_ctl_d;
	logic [iobc_pkg::TICK_W-1:0]  scan_cnt_q,  scan_cnt_d;
	logic [iobc_pkg::SHOT_W-1:0]  oneshot_q,   oneshot_d;
	logic [iobc_pkg::BYTE_W-1:0]  lcd_base_q,  lcd_base_d;
	logic                         lcd_on_q,    lcd_on_d;
	logic                         halt_q,      halt_d;
	logic                         buzz_q,      buzz_d;

	logic [iobc_pkg::BYTE_W-1:0]  rd_byte;
	logic [iobc_pkg::BYTE_W-1:0]  pend_masked;
	logic [iobc_pkg::BYTE_W-1:0]  key_mask;
	iobc_pkg::map_res_t           map_res;

	logic                         rsp_valid_q;
	logic [iobc_pkg::BYTE_W-1:0]  read_data_q;
	logic                         irq_request_q;
	logic [iobc_pkg::BYTE_W-1:0]  irq_vector_q;
	logic [iobc_pkg::KIND_W-1:0]  map_kind_q;
	logic [iobc_pkg::PHYS_W-1:0]  map_phys_q;
	logic                         halted_q;
	logic                         lcd_en_q;
	logic [iobc_pkg::BYTE_W-1:0]  lcd_base_out_q;
	logic                         buzz_out_q;

	assign adv       = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv;
	assign in_fire   = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_type_s1 <= req_type;
			port_s1     <= port;
			mem_addr_s1 <= mem_addr;
			data_s1     <= data;
			key_row_s1  <= key_row;
			key_bit_s1  <= key_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_unit_q <= iobc_pkg::TICK_UNIT_RST;
			bit3_ram_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iobc_pkg::CFG_TICK_UNIT: tick_unit_q <= cfg_data;
				iobc_pkg::CFG_BIT3_RAM:  bit3_ram_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	iobc_map #(
		.RAM_PAGE_CNT(RAM_PAGE_CNT),
		.ROM_PAGE_CNT(ROM_PAGE_CNT)
	) u_map (
		.sel     (bank_sel_q[mem_addr_s1[19:17]]),
		.bank    (mem_addr_s1[19:17]),
		.offset  (mem_addr_s1[iobc_pkg::OFFS_W-1:0]),
		.bit3_ram(bit3_ram_q),
		.res     (map_res)
	);

	always_comb begin
		rd_byte = iobc_pkg::OPEN_BUS;
		if (port_s1 == iobc_pkg::P_IRQ_EN) begin
			rd_byte = irq_en_q;
		end else if (port_s1 == iobc_pkg::P_ID) begin
			rd_byte = iobc_pkg::ID_VALUE;
		end else if (port_s1 == iobc_pkg::P_KEYS) begin
			rd_byte = (scan_row_q != '0 && scan_row_q <= 4'd10) ?
				key_mat_q[scan_row_q - 4'd1] : '0;
		end else if (port_s1 == iobc_pkg::P_STAT0) begin
			rd_byte = '0;
		end else if (port_s1 == iobc_pkg::P_STAT1) begin
			rd_byte = iobc_pkg::STAT1_VALUE;
		end else if (port_s1[15:4] == iobc_pkg::P_ZERO_BLK[15:4]) begin
			rd_byte = '0;
		end
	end

	assign key_mask = 8'b1 << key_bit_s1;

	always_comb begin
		irq_en_d   = irq_en_q;
		irq_pend_d = irq_pend_q;
		bank_sel_d = bank_sel_q;
		key_mat_d  = key_mat_q;
		scan_row_d = scan_row_q;
		scan_ctl_d = scan_ctl_q;
		scan_cnt_d = scan_cnt_q;
		oneshot_d  = oneshot_q;
		lcd_base_d = lcd_base_q;
		lcd_on_d   = lcd_on_q;
		halt_d     = halt_q;
		buzz_d     = buzz_q;
		unique case (req_type_s1)
			iobc_pkg::REQ_IO_WRITE: begin
				if (port_s1 == iobc_pkg::P_LCD) begin
					lcd_on_d   = 1'b1;
					lcd_base_d = data_s1;
				end else if (port_s1[15:3] == iobc_pkg::P_BANK[15:3]) begin
					bank_sel_d[port_s1[2:0]] = data_s1[iobc_pkg::SEL_W-1:0];
				end else if (port_s1 == iobc_pkg::P_BUZZER) begin
					buzz_d = (data_s1 == iobc_pkg::BUZZ_ON_VAL);
				end else if (port_s1 == iobc_pkg::P_ONESHOT) begin
					oneshot_d = iobc_pkg::SHOT_W'(data_s1) * iobc_pkg::SHOT_W'(tick_unit_q);
				end else if (port_s1 == iobc_pkg::P_IRQ_EN) begin
					irq_en_d = data_s1;
				end else if (port_s1 == iobc_pkg::P_SCAN_CTL) begin
					scan_ctl_d = data_s1;
					if (!data_s1[0] || !scan_ctl_q[0]) begin
						scan_row_d = '0;
						irq_pend_d = irq_pend_q & ~iobc_pkg::IRQ_SCAN_BOTH;
					end
				end else if (port_s1 == iobc_pkg::P_HALT) begin
					if (data_s1[0]) begin
						lcd_on_d = 1'b0;
						halt_d   = 1'b1;
					end
				end else if (port_s1 == iobc_pkg::P_IRQ_ACK) begin
					irq_pend_d = irq_pend_q & ~data_s1;
				end
			end
			iobc_pkg::REQ_TICK: begin
				if (scan_cnt_q <= 16'd1) begin
					scan_cnt_d = tick_unit_q;
					if (!scan_ctl_q[0]) begin
						irq_pend_d = irq_pend_d | iobc_pkg::IRQ_SCAN;
					end else if (scan_row_q > iobc_pkg::LAST_ROW) begin
						scan_row_d = '0;
						irq_pend_d = irq_pend_d | iobc_pkg::IRQ_SCAN;
					end else begin
						scan_row_d = scan_row_q + 4'd1;
						irq_pend_d = irq_pend_d | iobc_pkg::IRQ_ROW;
					end
				end else begin
					scan_cnt_d = scan_cnt_q - 16'd1;
				end
				if (oneshot_q != '0) begin
					oneshot_d = oneshot_q - 24'd1;
					if (oneshot_q == 24'd1) begin
						irq_pend_d = irq_pend_d | iobc_pkg::IRQ_ONESHOT;
					end
				end
			end
			iobc_pkg::REQ_KEY_DOWN: begin
				if (key_row_s1 <= iobc_pkg::LAST_ROW) begin
					key_mat_d[key_row_s1] = key_mat_q[key_row_s1] | key_mask;
				end
			end
			iobc_pkg::REQ_KEY_UP: begin
				if (key_row_s1 <= iobc_pkg::LAST_ROW) begin
					key_mat_d[key_row_s1] = key_mat_q[key_row_s1] & ~key_mask;
				end
			end
			iobc_pkg::REQ_PWR_PRESS: begin
				if (!lcd_on_q) begin
					irq_en_d   = '0;
					irq_pend_d = '0;
					for (int i = 0; i < iobc_pkg::BANKS; i++) begin
						bank_sel_d[i] = '0;
					end
					scan_row_d = '0;
					scan_ctl_d = iobc_pkg::SCAN_CTL_RST;
					scan_cnt_d = tick_unit_q;
					oneshot_d  = '0;
					lcd_base_d = '0;
					lcd_on_d   = 1'b1;
					halt_d     = 1'b0;
					buzz_d     = 1'b0;
				end else begin
					irq_pend_d = irq_pend_q | iobc_pkg::IRQ_POWER;
				end
			end
			iobc_pkg::REQ_IO_READ, iobc_pkg::REQ_MAP_QUERY, iobc_pkg::REQ_PWR_REL: ;
			default: ;
		endcase
	end

	assign pend_masked = irq_pend_d & ~iobc_pkg::bit_rev(irq_en_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_en_q   <= '0;
			irq_pend_q <= '0;
			for (int i = 0; i < iobc_pkg::BANKS; i++) begin
				bank_sel_q[i] <= '0;
			end
			for (int i = 0; i < iobc_pkg::KEY_ROWS; i++) begin
				key_mat_q[i] <= '0;
			end
			scan_row_q <= '0;
			scan_ctl_q <= iobc_pkg::SCAN_CTL_RST;
			scan_cnt_q <= iobc_pkg::TICK_UNIT_RST;
			oneshot_q  <= '0;
			lcd_base_q <= '0;
			lcd_on_q   <= 1'b1;
			halt_q     <= 1'b0;
			buzz_q     <= 1'b0;
		end else if (adv) begin
			irq_en_q   <= irq_en_d;
			irq_pend_q <= irq_pend_d;
			bank_sel_q <= bank_sel_d;
			key_mat_q  <= key_mat_d;
			scan_row_q <= scan_row_d;
			scan_ctl_q <= scan_ctl_d;
			scan_cnt_q <= scan_cnt_d;
			oneshot_q  <= oneshot_d;
			lcd_base_q <= lcd_base_d;
			lcd_on_q   <= lcd_on_d;
			halt_q     <= halt_d;
			buzz_q     <= buzz_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_data_q    <= (req_type_s1 == iobc_pkg::REQ_IO_READ) ? rd_byte : '0;
			irq_request_q  <= (pend_masked != '0);
			irq_vector_q   <= iobc_pkg::irq_vec(pend_masked);
			map_kind_q     <= (req_type_s1 == iobc_pkg::REQ_MAP_QUERY) ?
				map_res.kind : iobc_pkg::KIND_NONE;
			map_phys_q     <= (req_type_s1 == iobc_pkg::REQ_MAP_QUERY) ? map_res.phys : '0;
			halted_q       <= halt_d;
			lcd_en_q       <= lcd_on_d;
			lcd_base_out_q <= lcd_base_d;
			buzz_out_q     <= buzz_d;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign read_data      = read_data_q;
	assign irq_request    = irq_request_q;
	assign irq_vector     = irq_vector_q;
	assign map_kind       = map_kind_q;
	assign map_phys_addr  = map_phys_q;
	assign cpu_halted     = halted_q;
	assign lcd_enabled    = lcd_en_q;
	assign lcd_base       = lcd_base_out_q;
	assign buzzer_enabled = buzz_out_q;

	`IOBC_ASSERT_ALWAYS(a_scan_row_range, scan_row_q <= 4'd10, "scan row beyond last row")
	`IOBC_ASSERT_NEXT(a_adv_gives_result, adv, rsp_valid_q, "advanced item left no result")
	`IOBC_ASSERT_IMP(a_vector_range, rsp_valid_q, (irq_request_q ? (irq_vector_q[7:3] == 5'h1F) : (irq_vector_q == '0)), "interrupt vector out of range")
	`IOBC_ASSERT_IMP(a_unmapped_zero, rsp_valid_q && map_kind_q == iobc_pkg::KIND_NONE, map_phys_q == '0, "unmapped result with address")

endmodule
